// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside of reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// The condition must never be true outside of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// File: hdl/stlm_pkg.sv
// ----------------------------------------------------------------------------
// stlm_pkg
// Shared widths, defaults and codes of the sorted two-list merge.
// ----------------------------------------------------------------------------
package stlm_pkg;

    // Width of one list element and of one merged result.
    localparam int VALUE_W = 32;

    // Default capacity of each list.
    localparam int LIST_DEPTH_DEF = 32;

    // Request kinds carried on the slave-side tuser bit.
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_END    = 1'b1;

    // Bit positions in the master-side tuser.
    localparam int USER_EMPTY_BIT    = 0;
    localparam int USER_OVERFLOW_BIT = 1;
    localparam int OUT_USER_W        = 2;

endpackage

// File: hdl/stlm_ram.sv
// ----------------------------------------------------------------------------
// stlm_ram
// Simple dual-port list store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module stlm_ram
    import stlm_pkg::*;
#(
    parameter int DEPTH  = LIST_DEPTH_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [ADDR_W-1:0]         i_waddr,
    input  logic signed [VALUE_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0]         i_raddr,
    output logic signed [VALUE_W-1:0] o_rdata
);

    logic signed [VALUE_W-1:0] r_mem [DEPTH];
    logic signed [VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data is registered: it appears in the cycle after the address.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/sorted_two_list_merge.sv
// ----------------------------------------------------------------------------
// sorted_two_list_merge
// Loads two ascending lists of signed values and streams their stable merge.
// ----------------------------------------------------------------------------
// The slave side takes one request per cycle while the block is loading.
// s_axis_tuser selects the request kind: append s_axis_tdata to the list
// being filled, or close that list. The first close switches loading to the
// second list; the second close starts the merge and holds s_axis_tready low
// until the last result has been registered.
// Each list holds LIST_DEPTH elements; appends beyond that are dropped and
// the overflow flag is set on every result of the run.
// The first result is registered once the output register is free after the
// closing request is accepted; the head elements are read from the two list
// memories at the edge that accepts it. After that one result per cycle
// leaves while m_axis_tready is high, and the merge waits while the receiver
// stalls. The rate is set by the one read port of each list memory feeding
// the compare.
// When both lists are empty a single result with the empty flag and tlast
// is sent. A stalled receiver simply freezes the merge: the output register
// holds its request and the read addresses stay put.
// Reset (synchronous, active low) empties both lists and the output stage;
// the memory contents are not cleared, only entries below the counts are read.
// ----------------------------------------------------------------------------
module sorted_two_list_merge
    import stlm_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Slave side: load requests.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [VALUE_W-1:0]    s_axis_tdata,   // [31:0] value
    input  logic                  s_axis_tuser,   // [0] command
    // Master side: merged results.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [VALUE_W-1:0]    m_axis_tdata,   // [31:0] value_res
    output logic                  m_axis_tlast,   // last
    output logic [OUT_USER_W-1:0] m_axis_tuser    // [0] empty_res, [1] overflow
);

`include "assert_macros.svh"

    localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);

    typedef enum logic [0:0] {
        ST_LOAD,
        ST_MERGE
    } t_state;

    t_state r_state, n_state;

    // Fill counts of both lists and read positions during the merge.
    logic [CNT_W-1:0] r_cnt_a, n_cnt_a;
    logic [CNT_W-1:0] r_cnt_b, n_cnt_b;
    logic [CNT_W-1:0] r_idx_a, n_idx_a;
    logic [CNT_W-1:0] r_idx_b, n_idx_b;
    logic             r_fill_b, n_fill_b;
    logic             r_drop, n_drop;

    // Output register.
    logic                      r_out_valid, n_out_valid;
    logic signed [VALUE_W-1:0] r_out_value, n_out_value;
    logic                      r_out_last, n_out_last;
    logic                      r_out_empty, n_out_empty;
    logic                      r_out_ovf, n_out_ovf;

    // Memory ports.
    logic                      w_we_a, w_we_b;
    logic [ADDR_W-1:0]         w_waddr;
    logic signed [VALUE_W-1:0] w_head_a, w_head_b;

    logic w_in_accept;
    logic w_out_free;
    logic w_out_load;
    logic w_take_a;
    logic w_has_a, w_has_b;

    assign s_axis_tready = (r_state == ST_LOAD);
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    assign w_has_a  = (r_idx_a < r_cnt_a);
    assign w_has_b  = (r_idx_b < r_cnt_b);
    // Stable merge: on equal heads the first list wins.
    assign w_take_a = !w_has_b || (w_has_a && (w_head_a <= w_head_b));

    // Appends go to the list being filled while it has room.
    assign w_waddr = r_fill_b ? r_cnt_b[ADDR_W-1:0] : r_cnt_a[ADDR_W-1:0];
    assign w_we_a  = w_in_accept && (s_axis_tuser == CMD_APPEND) && !r_fill_b
                     && (r_cnt_a < CNT_W'(LIST_DEPTH));
    assign w_we_b  = w_in_accept && (s_axis_tuser == CMD_APPEND) && r_fill_b
                     && (r_cnt_b < CNT_W'(LIST_DEPTH));

    stlm_ram #(
        .DEPTH  (LIST_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (w_waddr),
        .i_wdata (s_axis_tdata),
        .i_raddr (n_idx_a[ADDR_W-1:0]),
        .o_rdata (w_head_a)
    );

    stlm_ram #(
        .DEPTH  (LIST_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (w_waddr),
        .i_wdata (s_axis_tdata),
        .i_raddr (n_idx_b[ADDR_W-1:0]),
        .o_rdata (w_head_b)
    );

    // The read address is always the next head position, so the memory
    // output lines up with r_idx_a and r_idx_b in the following cycle.
    always_comb begin
        n_state     = r_state;
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_idx_a     = r_idx_a;
        n_idx_b     = r_idx_b;
        n_fill_b    = r_fill_b;
        n_drop      = r_drop;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        n_out_empty = r_out_empty;
        n_out_ovf   = r_out_ovf;
        w_out_load  = 1'b0;

        case (r_state)
            ST_LOAD: begin
                if (w_in_accept) begin
                    if (s_axis_tuser == CMD_APPEND) begin
                        if (w_we_a) begin
                            n_cnt_a = r_cnt_a + CNT_W'(1);
                        end else if (w_we_b) begin
                            n_cnt_b = r_cnt_b + CNT_W'(1);
                        end else begin
                            n_drop = 1'b1;
                        end
                    end else if (!r_fill_b) begin
                        n_fill_b = 1'b1;
                    end else begin
                        n_state = ST_MERGE;
                    end
                end
            end
            ST_MERGE: begin
                if (w_out_free) begin
                    w_out_load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_ovf   = r_drop;
                    if (!w_has_a && !w_has_b) begin
                        // Both lists empty: one flagged result.
                        n_out_value = '0;
                        n_out_last  = 1'b1;
                        n_out_empty = 1'b1;
                    end else begin
                        n_out_empty = 1'b0;
                        if (w_take_a) begin
                            n_out_value = w_head_a;
                            n_idx_a     = r_idx_a + CNT_W'(1);
                        end else begin
                            n_out_value = w_head_b;
                            n_idx_b     = r_idx_b + CNT_W'(1);
                        end
                        n_out_last = (n_idx_a == r_cnt_a) && (n_idx_b == r_cnt_b);
                    end
                    if (n_out_last) begin
                        n_state  = ST_LOAD;
                        n_cnt_a  = '0;
                        n_cnt_b  = '0;
                        n_idx_a  = '0;
                        n_idx_b  = '0;
                        n_fill_b = 1'b0;
                        n_drop   = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_idx_a     <= '0;
            r_idx_b     <= '0;
            r_fill_b    <= 1'b0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_idx_a     <= n_idx_a;
            r_idx_b     <= n_idx_b;
            r_fill_b    <= n_fill_b;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
        end
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
        r_out_empty <= n_out_empty;
        r_out_ovf   <= n_out_ovf;
    end

    assign m_axis_tvalid                    = r_out_valid;
    assign m_axis_tdata                     = r_out_value;
    assign m_axis_tlast                     = r_out_last;
    assign m_axis_tuser[USER_EMPTY_BIT]     = r_out_empty;
    assign m_axis_tuser[USER_OVERFLOW_BIT]  = r_out_ovf;

    // Read positions never pass the fill counts, which never pass capacity.
    `ASSERT_PROP(a_idx_in_range, i_clk, i_rst_n,
        (r_idx_a <= r_cnt_a) && (r_idx_b <= r_cnt_b), "merge index past fill count")
    `ASSERT_PROP(a_cnt_in_range, i_clk, i_rst_n,
        (r_cnt_a <= CNT_W'(LIST_DEPTH)) && (r_cnt_b <= CNT_W'(LIST_DEPTH)),
        "fill count past capacity")
    // Registering the final result leaves the block empty and loading.
    `ASSERT_PROP(a_run_end_clears, i_clk, i_rst_n,
        (w_out_load && n_out_last) |=>
            (r_cnt_a == '0) && (r_cnt_b == '0) && !r_fill_b && !r_drop
            && (r_state == ST_LOAD),
        "list state not cleared after final result")
    // An empty-run result is always the only, and hence last, result.
    `ASSERT_PROP(a_empty_is_last, i_clk, i_rst_n,
        (m_axis_tvalid && m_axis_tuser[USER_EMPTY_BIT]) |-> m_axis_tlast,
        "empty result without tlast")
    // A result is never overwritten while the receiver stalls.
    `ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n,
        w_out_load && r_out_valid && !m_axis_tready, "output register overwritten")

endmodule
